### sv/lz_window_decompressor_defines.svh
// assertion macros for the window decompressor
`ifndef LZ_WINDOW_DECOMPRESSOR_DEFINES_SVH
`define LZ_WINDOW_DECOMPRESSOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LZWD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("lzwd check failed");
`define LZWD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzwd check failed");
`else
`define LZWD_ASSERT(label, prop)
`define LZWD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/lzwd_pkg.sv
package lzwd_pkg;

	localparam int WIN_DEPTH = 1024;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int LEN_W     = 6;

	localparam logic [15:0] CTRL_FILL  = 16'hFF00;
	localparam logic [7:0]  END_TOKEN  = 8'hFF;
	localparam logic [7:0]  BLOCK_BASE = 8'hB9;
	localparam logic [LEN_W-1:0] LONG_LEN_BIAS  = LEN_W'(3);
	localparam logic [LEN_W-1:0] SHORT_LEN_BIAS = LEN_W'(2);

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LIT,
		CMD_COPY,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         data;
		logic [LEN_W-1:0]   len;
		logic [WIN_AW-1:0]  distance;
	} cmd_t;

endpackage

### sv/lz_window_decompressor.sv
// a literal byte is registered in the emit stage, then in the output register; a window copy
// sets the copy counter, then each byte is read into the emit stage and the output register
// throughput, while the output is not stalled: one literal per cycle; a copy emits one byte
// per cycle from the window memory's single read port and holds off input until it is done
// reset clears all parse state; the window reads as zero until written (fill count), no sweep
`include "lz_window_decompressor_defines.svh"

module lz_window_decompressor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [1:0] m_tuser,   // out_valid, stream_end
	output logic       m_tlast
);

	typedef enum logic [1:0] {
		PH_TOKEN,
		PH_AFTER,
		PH_LONG2,
		PH_BLOCK
	} phase_t;

	phase_t      phase_q;
	phase_t      phase_n;
	logic [15:0] ctrl_q;
	logic [15:0] ctrl_n;
	logic [7:0]  held_q;
	logic [7:0]  held_n;
	logic [6:0]  rem_q;
	logic [6:0]  rem_n;

	lzwd_pkg::cmd_t cmd;
	logic           accept;
	logic           tok;
	logic           flag;
	logic [7:0]     b;

	assign b      = s_tdata;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		phase_n  = phase_q;
		ctrl_n   = ctrl_q;
		held_n   = held_q;
		rem_n    = rem_q;
		tok      = 1'b0;
		flag     = ctrl_q[0];
		cmd.kind = lzwd_pkg::CMD_NONE;
		cmd.data = b;
		cmd.len  = '0;
		cmd.distance = '0;
		case (phase_q)
			PH_TOKEN: begin
				// shifter empty once only the fill bits have gone
				if (ctrl_q[15:9] == 7'd0) begin
					ctrl_n  = lzwd_pkg::CTRL_FILL | {8'h00, b};
					phase_n = PH_AFTER;
				end else begin
					ctrl_n = {1'b0, ctrl_q[15:1]};
					tok    = 1'b1;
					flag   = ctrl_q[1];
				end
			end
			PH_AFTER: begin
				tok = 1'b1;
			end
			PH_LONG2: begin
				cmd.kind = lzwd_pkg::CMD_COPY;
				cmd.distance = {held_q[1:0], b};
				cmd.len  = lzwd_pkg::LEN_W'(held_q[6:2]) + lzwd_pkg::LONG_LEN_BIAS;
				phase_n  = PH_TOKEN;
			end
			PH_BLOCK: begin
				cmd.kind = lzwd_pkg::CMD_LIT;
				rem_n    = rem_q - 1'b1;
				if (rem_q == 7'd1) begin
					phase_n = PH_TOKEN;
				end
			end
			default: begin
				phase_n = PH_TOKEN;
			end
		endcase

		if (tok) begin
			phase_n = PH_TOKEN;
			if (!flag) begin
				cmd.kind = lzwd_pkg::CMD_LIT;
			end else if (!b[7]) begin
				held_n  = b;
				phase_n = PH_LONG2;
			end else if (!b[6]) begin
				cmd.kind = lzwd_pkg::CMD_COPY;
				cmd.len  = lzwd_pkg::LEN_W'(b[5:4]) + lzwd_pkg::SHORT_LEN_BIAS;
				cmd.distance = lzwd_pkg::WIN_AW'(b[3:0]) + 1'b1;
			end else if (b == lzwd_pkg::END_TOKEN) begin
				cmd.kind = lzwd_pkg::CMD_END;
				ctrl_n   = '0;
				held_n   = '0;
				rem_n    = '0;
			end else begin
				rem_n   = 7'(b - lzwd_pkg::BLOCK_BASE + 8'd1);
				phase_n = PH_BLOCK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			ctrl_q  <= '0;
			held_q  <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			ctrl_q  <= ctrl_n;
			held_q  <= held_n;
			rem_q   <= rem_n;
		end
	end

	lzwd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (accept),
		.cmd       (cmd),
		.cmd_ready (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	`LZWD_ASSERT_NEXT(a_copy_blocks_input, accept && cmd.kind == lzwd_pkg::CMD_COPY, !s_tready)
	`LZWD_ASSERT_NEXT(a_end_resets_parse, accept && cmd.kind == lzwd_pkg::CMD_END, phase_q == PH_TOKEN && ctrl_q == 16'h0000)
	`LZWD_ASSERT(a_block_has_bytes, phase_q != PH_BLOCK || rem_q != 7'd0)
	`LZWD_ASSERT(a_end_result_form, !(m_tvalid && m_tuser[1]) || (m_tlast && !m_tuser[0] && m_tdata == 8'h00))

endmodule

### sv/lzwd_ram.sv
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/lzwd_window.sv
module lzwd_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lzwd_pkg::cmd_t cmd,
	output logic          cmd_ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // out_byte
	output logic [1:0]    m_tuser,   // out_valid, stream_end
	output logic          m_tlast
);

	localparam int AW = lzwd_pkg::WIN_AW;

	logic [AW-1:0]                wp_q;
	logic [AW:0]                  fill_q;
	logic [lzwd_pkg::LEN_W-1:0]   cnt_q;
	logic [AW-1:0]                dist_q;

	// emit stage: one byte waiting to be written and sent
	logic       vld_s2;
	logic       ram_s2;
	logic [7:0] byte_s2;
	logic       fwd_s2;
	logic [7:0] fbyte_s2;
	logic       hit_s2;
	logic       last_s2;
	logic       end_s2;

	logic       m_tvalid_q;
	logic [7:0] out_byte_q;
	logic       out_vld_q;
	logic       last_q;
	logic       end_q;

	logic          s2_adv;
	logic          s2_free;
	logic          copy_act;
	logic          issue;
	logic          take;
	logic [7:0]    rdata;
	logic [7:0]    s2_data;
	logic          we;
	logic [AW-1:0] ip;
	logic [AW-1:0] raddr;
	logic          hit;
	logic          fwd;

	assign s2_adv   = vld_s2 && (!m_tvalid_q || m_tready);
	assign s2_free  = !vld_s2 || s2_adv;
	assign copy_act = (cnt_q != '0);
	assign cmd_ready = !copy_act && s2_free;
	assign issue    = copy_act && s2_free;
	assign take     = cmd_valid && cmd_ready;

	// entries never written since reset or the last end token read as zero
	assign s2_data = ram_s2 ? (fwd_s2 ? fbyte_s2 : (hit_s2 ? rdata : 8'h00)) : byte_s2;
	assign we      = s2_adv && !end_s2;

	// position the issued byte will land at
	assign ip    = wp_q + {{(AW-1){1'b0}}, (vld_s2 && !end_s2)};
	assign raddr = ip - dist_q;
	assign hit   = fill_q[AW] || ({1'b0, raddr} < fill_q);
	// read of the entry written in this same cycle gets the new byte
	assign fwd   = we && (raddr == wp_q);

	lzwd_ram #(
		.WIDTH(8),
		.DEPTH(lzwd_pkg::WIN_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wp_q),
		.wdata (s2_data),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			vld_s2     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (take && cmd.kind == lzwd_pkg::CMD_END) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (we) begin
				wp_q <= wp_q + 1'b1;
				if (!fill_q[AW]) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			if (issue) begin
				cnt_q  <= cnt_q - 1'b1;
				vld_s2 <= 1'b1;
			end else if (take && (cmd.kind == lzwd_pkg::CMD_LIT
					|| cmd.kind == lzwd_pkg::CMD_END)) begin
				vld_s2 <= 1'b1;
			end else if (s2_adv) begin
				vld_s2 <= 1'b0;
			end
			if (take && cmd.kind == lzwd_pkg::CMD_COPY) begin
				cnt_q <= cmd.len;
			end

			if (s2_adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ram_s2   <= 1'b1;
			byte_s2  <= 8'h00;
			fwd_s2   <= fwd;
			fbyte_s2 <= s2_data;
			hit_s2   <= hit;
			last_s2  <= (cnt_q == lzwd_pkg::LEN_W'(1));
			end_s2   <= 1'b0;
		end else if (take) begin
			case (cmd.kind)
				lzwd_pkg::CMD_LIT: begin
					ram_s2  <= 1'b0;
					byte_s2 <= cmd.data;
					last_s2 <= 1'b1;
					end_s2  <= 1'b0;
				end
				lzwd_pkg::CMD_END: begin
					ram_s2  <= 1'b0;
					byte_s2 <= 8'h00;
					last_s2 <= 1'b1;
					end_s2  <= 1'b1;
				end
				lzwd_pkg::CMD_COPY: begin
					dist_q <= cmd.distance;
				end
				default: begin
				end
			endcase
		end
		if (s2_adv) begin
			out_byte_q <= s2_data;
			out_vld_q  <= !end_s2;
			last_q     <= last_s2;
			end_q      <= end_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {end_q, out_vld_q};
	assign m_tlast  = last_q;

endmodule

### verif/tb_lz_window_decompressor.sv
module tb_lz_window_decompressor;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET    = 270;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 30;

	typedef enum logic [1:0] {
		SEEK_TOKEN,
		GOT_CTRL,
		LONG_SECOND,
		IN_BLOCK
	} decode_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       stream_end;
	} out_beat_t;

	class decomp_scoreboard;
		logic [7:0]    window [1024];
		logic [9:0]    wr_ptr;
		logic [15:0]   ctrl_bits;
		decode_phase_t phase;
		logic [7:0]    held;
		logic [6:0]    block_left;
		out_beat_t     due [$];
		int            mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			foreach (window[i]) window[i] = 8'h00;
			wr_ptr     = '0;
			ctrl_bits  = '0;
			phase      = SEEK_TOKEN;
			held       = '0;
			block_left = '0;
		endfunction

		// next byte will be taken as a fresh control byte
		function bit wants_control();
			return phase == SEEK_TOKEN && (ctrl_bits >> 1) < 16'h0100;
		endfunction

		function void emit(logic [7:0] v);
			out_beat_t r;
			r.data       = v;
			r.valid      = 1'b1;
			r.last       = 1'b0;
			r.stream_end = 1'b0;
			due.push_back(r);
			window[wr_ptr] = v;
			wr_ptr++;
		endfunction

		// byte by byte, so overlapping copies repeat what they just wrote
		function void copy_back(logic [9:0] distance, int count);
			logic [9:0] src;
			for (int i = 0; i < count; i++) begin
				src = wr_ptr - distance;
				emit(window[src]);
			end
		endfunction

		function void note_byte(logic [7:0] b);
			int          before_n;
			logic [15:0] shifted;
			out_beat_t   fin_beat;
			before_n = due.size();
			case (phase)
				LONG_SECOND: begin
					phase = SEEK_TOKEN;
					copy_back({held[1:0], b}, int'(held[6:2]) + 3);
				end
				IN_BLOCK: begin
					emit(b);
					block_left--;
					if (block_left == 0) phase = SEEK_TOKEN;
				end
				default: begin
					shifted = ctrl_bits >> 1;
					if (phase == SEEK_TOKEN && shifted < 16'h0100) begin
						ctrl_bits = lzwd_pkg::CTRL_FILL | {8'h00, b};
						phase     = GOT_CTRL;
						return;
					end
					if (phase == SEEK_TOKEN) ctrl_bits = shifted;
					phase = SEEK_TOKEN;
					if (!ctrl_bits[0]) begin
						emit(b);
					end else if (!b[7]) begin
						held  = b;
						phase = LONG_SECOND;
					end else if (!b[6]) begin
						copy_back(10'(b[3:0]) + 10'd1, int'(b[5:4]) + 2);
					end else if (b == lzwd_pkg::END_TOKEN) begin
						clear();
						fin_beat = '{8'h00, 1'b0, 1'b0, 1'b1};
						due.push_back(fin_beat);
					end else begin
						block_left = 7'(b - lzwd_pkg::BLOCK_BASE + 8'd1);
						phase      = IN_BLOCK;
					end
				end
			endcase
			if (due.size() > before_n) due[due.size() - 1].last = 1'b1;
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_beat(logic [7:0] data, logic [1:0] user, logic last);
			out_beat_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected transfer data %02h user %b last %b",
					data, user, last));
				return;
			end
			want = due.pop_front();
			if (data !== want.data)
				report($sformatf("data %02h, wanted %02h", data, want.data));
			if (user[0] !== want.valid)
				report($sformatf("out_valid %b, wanted %b", user[0], want.valid));
			if (user[1] !== want.stream_end)
				report($sformatf("stream_end %b, wanted %b", user[1], want.stream_end));
			if (last !== want.last)
				report($sformatf("tlast %b, wanted %b (data %02h)", last, want.last, data));
		endtask
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	decomp_scoreboard sb = new();
	int items_sent  = 0;
	int quiet_count = 0;
	bit send_calm   = 1'b0;
	bit recv_calm   = 1'b0;

	lz_window_decompressor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// stretches with no idling come and go
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 19) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	task send_byte(input logic [7:0] b);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b);
		items_sent++;
	endtask

	// one control byte and up to eight tokens, cut short by an end token
	task send_group();
		logic [7:0] flags;
		logic [7:0] hi;
		logic [7:0] lo;
		int         pick;
		int         len;
		// realign after noise by feeding random bytes
		while (!sb.wants_control()) send_byte(8'($urandom));
		flags = 8'($urandom);
		send_byte(flags);
		for (int k = 0; k < 8; k++) begin
			if (!flags[k]) begin
				send_byte(8'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					hi = 8'($urandom_range(0, 127));
					lo = 8'($urandom);
					if ($urandom_range(0, 1)) begin
						hi[1:0] = 2'b00;
						lo      = 8'($urandom_range(0, 31));
					end
					send_byte(hi);
					send_byte(lo);
				end else if (pick < 68) begin
					send_byte(8'($urandom_range(8'h80, 8'hBF)));
				end else if (pick < 96) begin
					case ($urandom_range(0, 9))
						0: len = 70;
						1: len = $urandom_range(8, 70);
						default: len = $urandom_range(8, 12);
					endcase
					send_byte(8'(lzwd_pkg::BLOCK_BASE - 8'd1 + 8'(len)));
					repeat (len) send_byte(8'($urandom));
				end else begin
					send_byte(lzwd_pkg::END_TOKEN);
					break;
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// literals 00 and ff, long copy of 34 at distance zero, shortest and longest
		// short copies, long copy from 1023 back, shortest literal block, end
		send_byte(8'hFC);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7C);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hBF);
		send_byte(8'h03);
		send_byte(8'hFF);
		send_byte(8'hC0);
		repeat (8) send_byte(8'($urandom));
		send_byte(lzwd_pkg::END_TOKEN);

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			else
				send_group();
		end
		s_tvalid <= 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_wait(recv_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(m_tdata, m_tuser, m_tlast);
		end
	end

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_count = 0;
			end else begin
				quiet_count++;
				if (quiet_count >= WATCHDOG_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

endmodule
